/* rtl/pic_pkg.sv */
// ----------------------------------------------------------------------------
// pic_pkg
// shared types, codes and constants of the priority interrupt controller
// ----------------------------------------------------------------------------
package pic_pkg;

    localparam int NumSources = 5;

    localparam logic [15:0] AddrFlags  = 16'hFF0F;
    localparam logic [15:0] AddrEnable = 16'hFFFF;
    localparam logic [7:0]  VecBase    = 8'h40;

    localparam int InDataWidth  = 32;
    localparam int OutDataWidth = 24;

    typedef enum logic [2:0] {
        ACT_TICK       = 3'd0,
        ACT_READ       = 3'd1,
        ACT_WRITE      = 3'd2,
        ACT_ENABLE_ME  = 3'd3,
        ACT_DISABLE_ME = 3'd4
    } action_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [4:0]  request_bits;
        logic        vdma_active;
    } pic_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       address_hit;
        logic       dispatch;
        logic [7:0] vector;
        logic       wake_halt;
    } pic_result_t;

endpackage

/* rtl/pic_core.sv */
// ----------------------------------------------------------------------------
// pic_core
// register file, tick evaluation and priority dispatch for one transaction
// ----------------------------------------------------------------------------
module pic_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  pic_pkg::pic_item_t   item,
    output pic_pkg::pic_result_t result
);

    logic [7:0] enable_mask_reg;
    logic [7:0] enable_mask_next;
    logic [7:0] flag_bits_reg;
    logic [7:0] flag_bits_next;
    logic       master_enable_reg;
    logic       master_enable_next;

    logic       sel_flags;
    logic       sel_enable;
    logic [7:0] flags_ticked;
    logic [4:0] pending;
    logic [2:0] src_num;
    logic       src_found;

    assign sel_flags    = (item.address == pic_pkg::AddrFlags);
    assign sel_enable   = (item.address == pic_pkg::AddrEnable);
    assign flags_ticked = flag_bits_reg | {3'b000, item.request_bits};
    assign pending      = enable_mask_reg[4:0] & flags_ticked[4:0];

    // bit 0 has the highest priority
    always_comb
    begin
        src_num   = 3'd0;
        src_found = 1'b0;
        for (int n = pic_pkg::NumSources - 1; n >= 0; n--)
        begin
            if (pending[n])
            begin
                src_num   = 3'(n);
                src_found = 1'b1;
            end
        end
    end

    always_comb
    begin
        enable_mask_next   = enable_mask_reg;
        flag_bits_next     = flag_bits_reg;
        master_enable_next = master_enable_reg;
        result             = '0;
        unique case (item.action)
            pic_pkg::ACT_TICK:
            begin
                flag_bits_next   = flags_ticked;
                result.wake_halt = !item.vdma_active
                                   && (master_enable_reg || (flags_ticked != 8'h00));
                if (master_enable_reg && src_found)
                begin
                    flag_bits_next[src_num] = 1'b0;
                    master_enable_next      = 1'b0;
                    result.dispatch         = 1'b1;
                    result.vector           = pic_pkg::VecBase + {2'b00, src_num, 3'b000};
                end
            end
            pic_pkg::ACT_READ:
            begin
                if (sel_flags)
                begin
                    result.read_data   = flag_bits_reg;
                    result.address_hit = 1'b1;
                end
                else if (sel_enable)
                begin
                    result.read_data   = enable_mask_reg;
                    result.address_hit = 1'b1;
                end
            end
            pic_pkg::ACT_WRITE:
            begin
                if (sel_flags)
                begin
                    flag_bits_next     = item.write_data;
                    result.address_hit = 1'b1;
                end
                else if (sel_enable)
                begin
                    enable_mask_next   = item.write_data;
                    result.address_hit = 1'b1;
                end
            end
            pic_pkg::ACT_ENABLE_ME:  master_enable_next = 1'b1;
            pic_pkg::ACT_DISABLE_ME: master_enable_next = 1'b0;
            default:
            begin
                // unused action codes leave everything untouched
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_mask_reg   <= 8'h00;
            flag_bits_reg     <= 8'h00;
            master_enable_reg <= 1'b0;
        end
        else if (accept)
        begin
            enable_mask_reg   <= enable_mask_next;
            flag_bits_reg     <= flag_bits_next;
            master_enable_reg <= master_enable_next;
        end
    end

endmodule

/* rtl/priority_interrupt_controller_unit.sv */
// ----------------------------------------------------------------------------
// priority_interrupt_controller_unit
// fixed-priority five-source interrupt controller with stream channels
// ----------------------------------------------------------------------------
// Each input transaction carries one action in s_tuser (tick, bus read, bus
// write, master enable, master disable) and the bus address, write byte,
// request bits and video DMA flag in s_tdata. Every input transaction gives
// exactly one result transaction on the m_ side with read data, address hit,
// dispatch, vector and halt wake.
// The action is evaluated and the register state updated in the cycle the
// transaction is accepted; the result is registered in the output register,
// or in the skid register while the output stalls, and throughput is one
// transaction per cycle while m_tready stays high.
// A two-entry result buffer (output register plus skid register) sits between
// the channels: one more transaction is taken while a result waits, and
// s_tready drops only once both entries are full. No result is dropped while
// the receiver stalls.
// Reset clears the enable mask, the flags and the master enable, and empties
// the result buffer; s_tready is high straight after reset.
// ----------------------------------------------------------------------------
module priority_interrupt_controller_unit
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // address[15:0], write_data[23:16], request_bits[28:24], vdma_active[29], zero[31:30]
    input  logic [pic_pkg::InDataWidth-1:0]  s_tdata,
    // action[2:0]
    input  logic [2:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // read_data[7:0], address_hit[8], dispatch[9], vector[17:10], wake_halt[18],
    // zero[23:19]
    output logic [pic_pkg::OutDataWidth-1:0] m_tdata
);

    pic_pkg::pic_item_t   item;
    pic_pkg::pic_result_t result;
    pic_pkg::pic_result_t out_reg;
    pic_pkg::pic_result_t skid_reg;
    logic                 out_valid_reg;
    logic                 skid_valid_reg;
    logic                 accept;
    logic                 out_free;

    assign item.action       = s_tuser;
    assign item.address      = s_tdata[15:0];
    assign item.write_data   = s_tdata[23:16];
    assign item.request_bits = s_tdata[28:24];
    assign item.vdma_active  = s_tdata[29];

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    pic_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            // skid entry drains first, it is the older transaction
            out_valid_reg  <= skid_valid_reg || accept;
            skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (accept)
            begin
                out_reg <= result;
            end
        end
        else if (accept)
        begin
            skid_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b00000, out_reg.wake_halt, out_reg.vector, out_reg.dispatch,
                       out_reg.address_hit, out_reg.read_data};

endmodule

/* rtl/pic_checker.sv */
// ----------------------------------------------------------------------------
// pic_checker
// port-level assertions for the priority interrupt controller
// ----------------------------------------------------------------------------
module pic_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tready,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata
);

    // a stalled result stays presented
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result transaction withdrawn while stalled");

    // an empty result buffer always takes a transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result buffer");

    // vector is non-zero exactly on a dispatch, and then one of the five service addresses
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[9] == (m_tdata[17:10] != 8'h00))
                     && (!m_tdata[9] || m_tdata[17:10] == 8'h40 || m_tdata[17:10] == 8'h48
                         || m_tdata[17:10] == 8'h50 || m_tdata[17:10] == 8'h58
                         || m_tdata[17:10] == 8'h60))
        else $error("vector does not match dispatch");

    // a dispatching tick is never a bus access
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[9] |-> !m_tdata[8] && (m_tdata[7:0] == 8'h00))
        else $error("dispatch mixed with bus access result");

endmodule

bind priority_interrupt_controller_unit pic_checker u_pic_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
